// ===== rtl/core/ctsd_pkg.sv =====
package ctsd_pkg;

  localparam logic [7:0] NEUTRAL      = 8'd127;
  localparam logic [7:0] DRIVE_MAX    = 8'd255;
  localparam logic [7:0] CENTER_LO    = 8'd123;
  localparam logic [7:0] CENTER_HI    = 8'd131;
  localparam logic [7:0] OFFCENTER_LO = 8'd122;
  localparam logic [7:0] OFFCENTER_HI = 8'd132;
  localparam logic [7:0] TILT_MARGIN  = 8'd5;

  localparam int unsigned CfgIdxW = 4;

  // Mode numbers as seen on mode_now
  localparam logic [2:0] MODE_NUM_IDLE     = 3'd0;
  localparam logic [2:0] MODE_NUM_SWEEP    = 3'd1;
  localparam logic [2:0] MODE_NUM_CHECK    = 3'd2;
  localparam logic [2:0] MODE_NUM_PIVOT    = 3'd3;
  localparam logic [2:0] MODE_NUM_APPROACH = 3'd4;
  localparam logic [2:0] MODE_NUM_WAIT     = 3'd5;

  typedef enum logic [5:0] {
    MODE_IDLE     = 6'b000001,
    MODE_SWEEP    = 6'b000010,
    MODE_CHECK    = 6'b000100,
    MODE_PIVOT    = 6'b001000,
    MODE_APPROACH = 6'b010000,
    MODE_WAIT     = 6'b100000
  } seek_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PAN_DECREMENT     = 4'd0,
    REG_SWEEP_LOW         = 4'd1,
    REG_SWEEP_HIGH        = 4'd2,
    REG_PIVOT_RIGHT_LIMIT = 4'd3,
    REG_PIVOT_LEFT_LIMIT  = 4'd4,
    REG_CRUISE_OFFSET     = 4'd5,
    REG_FORWARD_MINIMUM   = 4'd6,
    REG_ARRIVAL_TILT      = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic       target_locked;
    logic [7:0] pan_position;
    logic [7:0] tilt_position;
    logic       camera_coarse;
    logic       start_request;
  } seek_in_t;

  typedef struct packed {
    logic [7:0] drive_x;
    logic [7:0] drive_y;
    logic [7:0] pan_command;
    logic       pan_command_valid;
    logic       coarse_request;
    logic [2:0] mode_now;
  } seek_out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [7:0]         data;
  } cfg_wr_t;

  typedef struct packed {
    logic [7:0] pan_decrement;
    logic [7:0] sweep_low;
    logic [7:0] sweep_high;
    logic [7:0] pivot_right_limit;
    logic [7:0] pivot_left_limit;
    logic [7:0] cruise_offset;
    logic [7:0] forward_minimum;
    logic [7:0] arrival_tilt;
  } seek_cfg_t;

  typedef struct packed {
    seek_mode_e mode;
    logic [7:0] sweep_pos;
    logic [7:0] turn_drive;
    logic [7:0] fwd_drive;
  } seek_state_t;

  function automatic logic [2:0] mode_num(input seek_mode_e m);
    logic [2:0] n;
    unique case (m)
      MODE_IDLE:     n = MODE_NUM_IDLE;
      MODE_SWEEP:    n = MODE_NUM_SWEEP;
      MODE_CHECK:    n = MODE_NUM_CHECK;
      MODE_PIVOT:    n = MODE_NUM_PIVOT;
      MODE_APPROACH: n = MODE_NUM_APPROACH;
      MODE_WAIT:     n = MODE_NUM_WAIT;
      default:       n = MODE_NUM_IDLE;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/core/ctsd_if.sv =====
interface ctsd_in_if import ctsd_pkg::*; ();
  logic     valid;
  logic     ready;
  seek_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ctsd_out_if import ctsd_pkg::*; ();
  logic      valid;
  logic      ready;
  seek_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ctsd_cfg_if import ctsd_pkg::*; ();
  logic    valid;
  logic    ready;
  cfg_wr_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/ctsd_cfg.sv =====
module ctsd_cfg import ctsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ctsd_cfg_if.sink   cfg_i,
  output seek_cfg_t  cfg_o
);

  seek_cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.payload.index)
        REG_PAN_DECREMENT:     cfg_d.pan_decrement     = cfg_i.payload.data;
        REG_SWEEP_LOW:         cfg_d.sweep_low         = cfg_i.payload.data;
        REG_SWEEP_HIGH:        cfg_d.sweep_high        = cfg_i.payload.data;
        REG_PIVOT_RIGHT_LIMIT: cfg_d.pivot_right_limit = cfg_i.payload.data;
        REG_PIVOT_LEFT_LIMIT:  cfg_d.pivot_left_limit  = cfg_i.payload.data;
        REG_CRUISE_OFFSET:     cfg_d.cruise_offset     = cfg_i.payload.data;
        REG_FORWARD_MINIMUM:   cfg_d.forward_minimum   = cfg_i.payload.data;
        REG_ARRIVAL_TILT:      cfg_d.arrival_tilt      = cfg_i.payload.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pan_decrement     <= 8'd5;
      cfg_q.sweep_low         <= 8'd97;
      cfg_q.sweep_high        <= 8'd157;
      cfg_q.pivot_right_limit <= 8'd105;
      cfg_q.pivot_left_limit  <= 8'd149;
      cfg_q.cruise_offset     <= 8'd20;
      cfg_q.forward_minimum   <= 8'd10;
      cfg_q.arrival_tilt      <= 8'd110;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/ctsd_step.sv =====
module ctsd_step import ctsd_pkg::*; (
  input  seek_cfg_t   cfg_i,
  input  seek_state_t state_i,
  input  seek_in_t    item_i,
  output seek_state_t state_o,
  output seek_out_t   res_o
);

  logic signed [9:0] pan_s;
  logic signed [9:0] sweep_diff;
  logic signed [9:0] mirror_x;
  logic signed [9:0] x;
  logic        [9:0] fwd_y;
  logic        [9:0] fwd_lo;
  logic        [8:0] resume_tilt;
  logic              pan_centered;
  logic              pan_off;
  logic        [7:0] pan_cmd;
  logic              pan_vld;
  logic              coarse_req;

  always_comb begin
    pan_s        = signed'({2'b00, item_i.pan_position});
    sweep_diff   = signed'({2'b00, state_i.sweep_pos}) - signed'({2'b00, cfg_i.pan_decrement});
    // 254 - pan: the pan angle mirrored about straight ahead
    mirror_x     = signed'({2'b00, NEUTRAL}) + signed'({2'b00, NEUTRAL}) - pan_s;
    fwd_y        = {2'b00, cfg_i.cruise_offset} + {2'b00, item_i.tilt_position};
    fwd_lo       = {2'b00, NEUTRAL} + {2'b00, cfg_i.forward_minimum};
    resume_tilt  = {1'b0, cfg_i.arrival_tilt} + {1'b0, TILT_MARGIN};
    pan_centered = (item_i.pan_position >= CENTER_LO) && (item_i.pan_position <= CENTER_HI);
    pan_off      = (item_i.pan_position <= OFFCENTER_LO) ||
                   (item_i.pan_position >= OFFCENTER_HI);
    x            = signed'({2'b00, NEUTRAL});

    state_o    = state_i;
    pan_cmd    = 8'd0;
    pan_vld    = 1'b0;
    coarse_req = 1'b0;

    unique case (state_i.mode)
      MODE_SWEEP: begin
        state_o.turn_drive = NEUTRAL;
        state_o.fwd_drive  = NEUTRAL;
        coarse_req         = !item_i.camera_coarse;
        // wrap when the step lands below the low bound, underflow included
        if (sweep_diff < signed'({2'b00, cfg_i.sweep_low})) begin
          state_o.sweep_pos = cfg_i.sweep_high;
        end else begin
          state_o.sweep_pos = sweep_diff[7:0];
        end
        pan_cmd       = state_o.sweep_pos;
        pan_vld       = 1'b1;
        state_o.mode  = MODE_CHECK;
      end
      MODE_CHECK: begin
        state_o.turn_drive = NEUTRAL;
        state_o.fwd_drive  = NEUTRAL;
        state_o.mode       = item_i.target_locked ? MODE_PIVOT : MODE_SWEEP;
      end
      MODE_PIVOT: begin
        if (!item_i.target_locked) begin
          state_o.mode = MODE_SWEEP;
        end else if (pan_centered) begin
          state_o.mode = MODE_APPROACH;
        end else begin
          state_o.fwd_drive = NEUTRAL;
          if (item_i.pan_position > NEUTRAL) begin
            x = mirror_x;
            if (x < 10'sd0) x = 10'sd0;
            if (x > signed'({2'b00, cfg_i.pivot_right_limit})) begin
              x = signed'({2'b00, cfg_i.pivot_right_limit});
            end
          end else if (item_i.pan_position < NEUTRAL) begin
            x = mirror_x;
            if (x > signed'({2'b00, DRIVE_MAX})) x = signed'({2'b00, DRIVE_MAX});
            if (x < signed'({2'b00, cfg_i.pivot_left_limit})) begin
              x = signed'({2'b00, cfg_i.pivot_left_limit});
            end
          end
          state_o.turn_drive = x[7:0];
        end
      end
      MODE_APPROACH: begin
        if (!item_i.target_locked) begin
          state_o.mode = MODE_SWEEP;
        end else if (item_i.tilt_position < cfg_i.arrival_tilt) begin
          state_o.mode = MODE_WAIT;
        end else begin
          if (fwd_y < fwd_lo) fwd_y = fwd_lo;
          if (fwd_y > {2'b00, DRIVE_MAX}) fwd_y = {2'b00, DRIVE_MAX};
          x = mirror_x;
          if (x < 10'sd0) x = 10'sd0;
          if (x > signed'({2'b00, DRIVE_MAX})) x = signed'({2'b00, DRIVE_MAX});
          state_o.turn_drive = x[7:0];
          state_o.fwd_drive  = fwd_y[7:0];
        end
      end
      MODE_WAIT: begin
        state_o.turn_drive = NEUTRAL;
        state_o.fwd_drive  = NEUTRAL;
        // pan leaving center outranks the tilt rising
        if (pan_off) begin
          state_o.mode = MODE_PIVOT;
        end else if ({1'b0, item_i.tilt_position} > resume_tilt) begin
          state_o.mode = MODE_APPROACH;
        end
      end
      default: begin
        state_o.mode = item_i.start_request ? MODE_SWEEP : MODE_IDLE;
      end
    endcase

    res_o.drive_x           = state_o.turn_drive;
    res_o.drive_y           = state_o.fwd_drive;
    res_o.pan_command       = pan_cmd;
    res_o.pan_command_valid = pan_vld;
    res_o.coarse_request    = coarse_req;
    res_o.mode_now          = mode_num(state_o.mode);
  end

endmodule

// ===== rtl/core/camera_target_seek_drive_fsm.sv =====
// Seek controller for a camera-guided drive.
//
// Channels: in_i carries one control tick (lock flag, pan and tilt
// positions, coarse flag, start request); out_o returns one result per
// tick (drive x/y, pan command with its valid bit, coarse request and the
// mode after the tick). cfg_i writes the eight tuning registers by index;
// it is always ready, indexes beyond the list are dropped. Write registers
// only while no tick is in flight.
//
// A tick taken on in_i is held in the input register, passes the seek
// step and is held in the result register before it is offered on out_o.
// One tick per cycle while out_o takes its results; the seek step is short
// compare and clamp logic between the two registers.
//
// Reset: mode idle, sweep position 0, both drives neutral (127), tuning
// registers at their defaults, both pipeline registers empty.
// Stall: while out_o is held, the result stays in place and one further
// tick is buffered in the input register; then in_i.ready drops.
module camera_target_seek_drive_fsm import ctsd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ctsd_in_if.sink   in_i,
  ctsd_out_if.source out_o,
  ctsd_cfg_if.sink  cfg_i
);

  seek_cfg_t   cfg;
  seek_state_t state_q, state_d;
  seek_in_t    in_q;
  logic        in_vld_q;
  seek_out_t   out_q, out_d;
  logic        out_vld_q;
  logic        fire;

  ctsd_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  ctsd_step u_step (
    .cfg_i   (cfg),
    .state_i (state_q),
    .item_i  (in_q),
    .state_o (state_d),
    .res_o   (out_d)
  );

  // advance a buffered tick when the result slot is free or draining
  assign fire        = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready  = !in_vld_q || fire;
  assign out_o.valid = out_vld_q;
  assign out_o.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      state_q.mode       <= MODE_IDLE;
      state_q.sweep_pos  <= 8'd0;
      state_q.turn_drive <= NEUTRAL;
      state_q.fwd_drive  <= NEUTRAL;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.payload;
    end
    if (fire) begin
      out_q <= out_d;
    end
  end

  a_res_follows_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_vld_q)
    else $error("result register not loaded after a step");

  a_mode_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_q.mode_now == mode_num(state_q.mode))
    else $error("reported mode differs from stored mode");

  a_pan_cmd_only_in_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.pan_command_valid |-> out_q.mode_now == MODE_NUM_CHECK)
    else $error("pan command issued outside a sweep step");

  a_pan_cmd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_q.pan_command_valid |-> out_q.pan_command == 8'd0)
    else $error("pan command nonzero without valid");

  a_coarse_with_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.coarse_request |-> out_q.pan_command_valid)
    else $error("coarse request outside a sweep step");

endmodule

// ===== tb/seek_checker.sv =====
`timescale 1ns / 1ps

module seek_checker import ctsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ctsd_in_if          in_mon,
  ctsd_out_if         out_mon,
  ctsd_cfg_if         cfg_mon,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);

  localparam int Mid        = NEUTRAL;
  localparam int DriveTop   = DRIVE_MAX;
  localparam int CenterLo   = CENTER_LO;
  localparam int CenterHi   = CENTER_HI;
  localparam int OffLo      = OFFCENTER_LO;
  localparam int OffHi      = OFFCENTER_HI;
  localparam int TiltMargin = TILT_MARGIN;

  logic [2:0]  mode_q;
  logic [7:0]  sweep_pos_q;
  logic [7:0]  turn_q;
  logic [7:0]  fwd_q;
  seek_cfg_t   cfg_q;
  seek_out_t   drive_expect_q[$];
  seek_out_t   got;
  seek_out_t   want;
  int unsigned errors;

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 100) begin
      $display("%0t mismatch: %s", $time, msg);
    end
  endtask

  // One control tick of the seek machine; updates the predicted state.
  function automatic seek_out_t seek_step(input seek_in_t t);
    seek_out_t r;
    int pan;
    int tilt;
    int x;
    int y;
    int lo;
    pan  = int'(t.pan_position);
    tilt = int'(t.tilt_position);
    r    = '0;
    case (mode_q)
      MODE_NUM_SWEEP: begin
        turn_q = NEUTRAL;
        fwd_q  = NEUTRAL;
        r.coarse_request = !t.camera_coarse;
        // signed difference: a step past zero counts as below the low bound
        y = int'(sweep_pos_q) - int'(cfg_q.pan_decrement);
        if (y < int'(cfg_q.sweep_low)) begin
          sweep_pos_q = cfg_q.sweep_high;
        end else begin
          sweep_pos_q = y[7:0];
        end
        r.pan_command       = sweep_pos_q;
        r.pan_command_valid = 1'b1;
        mode_q = MODE_NUM_CHECK;
      end
      MODE_NUM_CHECK: begin
        turn_q = NEUTRAL;
        fwd_q  = NEUTRAL;
        mode_q = t.target_locked ? MODE_NUM_PIVOT : MODE_NUM_SWEEP;
      end
      MODE_NUM_PIVOT: begin
        if (!t.target_locked) begin
          mode_q = MODE_NUM_SWEEP;
        end else if (pan >= CenterLo && pan <= CenterHi) begin
          mode_q = MODE_NUM_APPROACH;
        end else begin
          fwd_q = NEUTRAL;
          x = Mid;
          if (pan > Mid) begin
            x = Mid - (pan - Mid);
            if (x < 0) x = 0;
            if (x > int'(cfg_q.pivot_right_limit)) x = int'(cfg_q.pivot_right_limit);
          end else if (pan < Mid) begin
            x = Mid + (Mid - pan);
            if (x > DriveTop) x = DriveTop;
            if (x < int'(cfg_q.pivot_left_limit)) x = int'(cfg_q.pivot_left_limit);
          end
          turn_q = x[7:0];
        end
      end
      MODE_NUM_APPROACH: begin
        if (!t.target_locked) begin
          mode_q = MODE_NUM_SWEEP;
        end else if (tilt < int'(cfg_q.arrival_tilt)) begin
          mode_q = MODE_NUM_WAIT;
        end else begin
          y  = Mid + int'(cfg_q.cruise_offset) - (Mid - tilt);
          lo = Mid + int'(cfg_q.forward_minimum);
          if (y < lo) y = lo;
          if (y > DriveTop) y = DriveTop;
          x = Mid - (pan - Mid);
          if (x < 0) x = 0;
          if (x > DriveTop) x = DriveTop;
          turn_q = x[7:0];
          fwd_q  = y[7:0];
        end
      end
      MODE_NUM_WAIT: begin
        turn_q = NEUTRAL;
        fwd_q  = NEUTRAL;
        if (tilt > int'(cfg_q.arrival_tilt) + TiltMargin) mode_q = MODE_NUM_APPROACH;
        // pan off center overrides a tilt rise
        if (pan <= OffLo || pan >= OffHi) mode_q = MODE_NUM_PIVOT;
      end
      default: begin
        mode_q = t.start_request ? MODE_NUM_SWEEP : MODE_NUM_IDLE;
      end
    endcase
    r.drive_x  = turn_q;
    r.drive_y  = fwd_q;
    r.mode_now = mode_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      = MODE_NUM_IDLE;
      sweep_pos_q = 8'd0;
      turn_q      = NEUTRAL;
      fwd_q       = NEUTRAL;
      cfg_q.pan_decrement     = 8'd5;
      cfg_q.sweep_low         = 8'd97;
      cfg_q.sweep_high        = 8'd157;
      cfg_q.pivot_right_limit = 8'd105;
      cfg_q.pivot_left_limit  = 8'd149;
      cfg_q.cruise_offset     = 8'd20;
      cfg_q.forward_minimum   = 8'd10;
      cfg_q.arrival_tilt      = 8'd110;
      drive_expect_q.delete();
      errors = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.payload;
        if (drive_expect_q.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing expected", got));
        end else begin
          want = drive_expect_q.pop_front();
          if (got.drive_x !== want.drive_x)
            report_mismatch($sformatf("drive_x got %0d want %0d", got.drive_x, want.drive_x));
          if (got.drive_y !== want.drive_y)
            report_mismatch($sformatf("drive_y got %0d want %0d", got.drive_y, want.drive_y));
          if (got.pan_command !== want.pan_command)
            report_mismatch($sformatf("pan_command got %0d want %0d",
                                      got.pan_command, want.pan_command));
          if (got.pan_command_valid !== want.pan_command_valid)
            report_mismatch($sformatf("pan_command_valid got %b want %b",
                                      got.pan_command_valid, want.pan_command_valid));
          if (got.coarse_request !== want.coarse_request)
            report_mismatch($sformatf("coarse_request got %b want %b",
                                      got.coarse_request, want.coarse_request));
          if (got.mode_now !== want.mode_now)
            report_mismatch($sformatf("mode_now got %0d want %0d", got.mode_now, want.mode_now));
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.payload.index)
          REG_PAN_DECREMENT:     cfg_q.pan_decrement     = cfg_mon.payload.data;
          REG_SWEEP_LOW:         cfg_q.sweep_low         = cfg_mon.payload.data;
          REG_SWEEP_HIGH:        cfg_q.sweep_high        = cfg_mon.payload.data;
          REG_PIVOT_RIGHT_LIMIT: cfg_q.pivot_right_limit = cfg_mon.payload.data;
          REG_PIVOT_LEFT_LIMIT:  cfg_q.pivot_left_limit  = cfg_mon.payload.data;
          REG_CRUISE_OFFSET:     cfg_q.cruise_offset     = cfg_mon.payload.data;
          REG_FORWARD_MINIMUM:   cfg_q.forward_minimum   = cfg_mon.payload.data;
          REG_ARRIVAL_TILT:      cfg_q.arrival_tilt      = cfg_mon.payload.data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        drive_expect_q.push_back(seek_step(in_mon.payload));
      end
      pending_o    <= drive_expect_q.size();
      fail_count_o <= errors;
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import ctsd_pkg::*;

  localparam int unsigned DeadLimit = 2000;
  localparam int unsigned BacklogCycles = 80;
  localparam logic [CfgIdxW-1:0] REG_UNMAPPED = 4'd15;

  logic clk_i = 1'b0;
  logic rst_ni;

  ctsd_in_if  in_if ();
  ctsd_out_if out_if ();
  ctsd_cfg_if cfg_if ();

  int unsigned pending_ticks;
  int unsigned mismatches;
  int unsigned ticks_sent = 0;
  int unsigned dead_cycles = 0;
  int unsigned idle_pct = 0;
  bit          no_idle = 1'b0;
  bit          backlog_done = 1'b0;
  logic [7:0]  arrival_now = 8'd110;

  always #6 clk_i = ~clk_i;

  camera_target_seek_drive_fsm dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  seek_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .cfg_mon      (cfg_if),
    .pending_o    (pending_ticks),
    .fail_count_o (mismatches)
  );

  function automatic seek_in_t pack_tick(input logic locked, input logic [7:0] pan,
                                         input logic [7:0] tilt, input logic coarse,
                                         input logic start);
    seek_in_t t;
    t.target_locked = locked;
    t.pan_position  = pan;
    t.tilt_position = tilt;
    t.camera_coarse = coarse;
    t.start_request = start;
    return t;
  endfunction

  // Mostly locked ticks; pan is often near center and tilt often near the arrival bound.
  function automatic seek_in_t rand_tick();
    seek_in_t t;
    int v;
    t.target_locked = ($urandom_range(99) < 85);
    t.camera_coarse = 1'($urandom_range(1));
    t.start_request = 1'($urandom_range(1));
    if ($urandom_range(99) < 45) begin
      t.pan_position = 8'($urandom_range(136, 118));
    end else begin
      t.pan_position = 8'($urandom_range(255));
    end
    if ($urandom_range(1) == 0) begin
      t.tilt_position = 8'($urandom_range(255));
    end else begin
      v = int'(arrival_now) + int'($urandom_range(16)) - 8;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      t.tilt_position = v[7:0];
    end
    return t;
  endfunction

  task automatic send_tick(input seek_in_t t);
    if (!no_idle && idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= t;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    ticks_sent++;
  endtask

  // Stop offering and hold until every result is back.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_ticks != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_cfg(input seek_cfg_t c);
    cfg_wr_t w[9];
    w[0] = '{REG_PAN_DECREMENT, c.pan_decrement};
    w[1] = '{REG_SWEEP_LOW, c.sweep_low};
    w[2] = '{REG_SWEEP_HIGH, c.sweep_high};
    w[3] = '{REG_PIVOT_RIGHT_LIMIT, c.pivot_right_limit};
    w[4] = '{REG_PIVOT_LEFT_LIMIT, c.pivot_left_limit};
    w[5] = '{REG_CRUISE_OFFSET, c.cruise_offset};
    w[6] = '{REG_FORWARD_MINIMUM, c.forward_minimum};
    w[7] = '{REG_ARRIVAL_TILT, c.arrival_tilt};
    // unmapped index last, so any aliasing onto a real register shows
    w[8] = '{REG_UNMAPPED, 8'($urandom_range(255))};
    foreach (w[i]) begin
      cfg_if.valid   <= 1'b1;
      cfg_if.payload <= w[i];
      @(posedge clk_i);
      while (!cfg_if.ready) @(posedge clk_i);
    end
    cfg_if.valid <= 1'b0;
    arrival_now = c.arrival_tilt;
  endtask

  // Result side: random ready drops, plus one long hold to back up the input.
  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!backlog_done && ticks_sent >= 700) begin
        backlog_done = 1'b1;
        out_if.ready <= 1'b0;
        repeat (BacklogCycles) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end else if (!no_idle && idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(15, 1)) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      dead_cycles <= 0;
    end else if (dead_cycles >= DeadLimit) begin
      $display("timeout after %0d cycles without a transfer", dead_cycles);
      $display("FAIL camera_target_seek_drive_fsm");
      $finish;
    end else begin
      dead_cycles <= dead_cycles + 1;
    end
  end

  initial begin : stimulus
    seek_cfg_t c;
    rst_ni         <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.payload  <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.payload <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed walk through every mode at the default tuning
    send_tick(pack_tick(1'b1, 8'd255, 8'd255, 1'b1, 1'b0));  // idle holds
    send_tick(pack_tick(1'b0, 8'd0, 8'd0, 1'b0, 1'b0));
    send_tick(pack_tick(1'b0, 8'd0, 8'd0, 1'b0, 1'b1));      // start -> sweep
    send_tick(pack_tick(1'b1, 8'd127, 8'd128, 1'b0, 1'b1));  // wrap from 0, coarse asked
    send_tick(pack_tick(1'b0, 8'd127, 8'd128, 1'b1, 1'b0));  // no lock -> sweep
    send_tick(pack_tick(1'b0, 8'd127, 8'd128, 1'b1, 1'b0));  // already coarse
    send_tick(pack_tick(1'b1, 8'd200, 8'd128, 1'b0, 1'b0));  // lock -> pivot
    send_tick(pack_tick(1'b1, 8'd255, 8'd128, 1'b0, 1'b1));  // right turn floors at 0
    send_tick(pack_tick(1'b1, 8'd132, 8'd128, 1'b0, 1'b0));  // right limit
    send_tick(pack_tick(1'b1, 8'd0, 8'd128, 1'b0, 1'b0));    // hard left
    send_tick(pack_tick(1'b1, 8'd122, 8'd128, 1'b0, 1'b0));  // left limit
    send_tick(pack_tick(1'b1, 8'd123, 8'd128, 1'b0, 1'b0));  // centered -> approach
    send_tick(pack_tick(1'b1, 8'd255, 8'd255, 1'b0, 1'b0));  // forward saturates
    send_tick(pack_tick(1'b1, 8'd0, 8'd110, 1'b0, 1'b0));    // forward floor
    send_tick(pack_tick(1'b1, 8'd127, 8'd109, 1'b0, 1'b0));  // arrived -> wait
    send_tick(pack_tick(1'b1, 8'd121, 8'd116, 1'b0, 1'b0));  // both moves, pivot wins
    send_tick(pack_tick(1'b1, 8'd131, 8'd128, 1'b0, 1'b0));  // -> approach
    send_tick(pack_tick(1'b1, 8'd127, 8'd0, 1'b0, 1'b0));    // -> wait
    send_tick(pack_tick(1'b1, 8'd123, 8'd115, 1'b0, 1'b0));  // stays in wait
    send_tick(pack_tick(1'b1, 8'd132, 8'd100, 1'b0, 1'b0));  // pan off -> pivot
    send_tick(pack_tick(1'b1, 8'd127, 8'd128, 1'b0, 1'b0));  // -> approach
    send_tick(pack_tick(1'b1, 8'd127, 8'd0, 1'b0, 1'b0));    // -> wait
    send_tick(pack_tick(1'b1, 8'd131, 8'd116, 1'b0, 1'b0));  // tilt rise -> approach
    send_tick(pack_tick(1'b0, 8'd127, 8'd128, 1'b0, 1'b0));  // lock lost -> sweep
    send_tick(pack_tick(1'b1, 8'd127, 8'd128, 1'b0, 1'b0));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: c = '{8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
        1: c = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd128, 8'd128, 8'd250};
        default: begin
          c.pan_decrement     = 8'($urandom_range(255, 1));
          c.sweep_low         = 8'($urandom_range(255));
          c.sweep_high        = 8'($urandom_range(255));
          c.pivot_right_limit = 8'($urandom_range(255));
          c.pivot_left_limit  = 8'($urandom_range(255));
          c.cruise_offset     = 8'($urandom_range(128));
          c.forward_minimum   = 8'($urandom_range(128));
          c.arrival_tilt      = 8'($urandom_range(250));
        end
      endcase
      apply_cfg(c);
      no_idle = (ph == 5);
      for (int n = 0; n < 290; n++) begin
        if (n % 50 == 0) begin
          idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(40, 5);
        end
        send_tick(rand_tick());
      end
      drain();
    end

    repeat (6) @(posedge clk_i);
    if (mismatches == 0 && pending_ticks == 0) begin
      $display("PASS camera_target_seek_drive_fsm");
    end else begin
      $display("FAIL camera_target_seek_drive_fsm");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ctsd_pkg.sv
rtl/core/ctsd_if.sv
rtl/core/ctsd_cfg.sv
rtl/core/ctsd_step.sv
rtl/core/camera_target_seek_drive_fsm.sv
tb/seek_checker.sv
tb/tb.sv
